>>> hdl/cpt_pkg.sv
// Shared widths, region codes and item types for the closest-point-on-triangle block.
package cpt_pkg;

  localparam int CW   = 24;          // coordinate field width
  localparam int DIFW = CW + 1;      // vertex difference width
  localparam int DW   = 52;          // dot product width
  localparam int SW   = 27;          // multiplier split width
  localparam int NCH  = 4;           // chunks in a weight word
  localparam int VW   = SW * NCH;    // weight and 2x2 determinant width
  localparam int DENW = VW + 2;      // divisor width
  localparam int NW   = 136;         // numerator width
  localparam int QB   = 26;          // quotient bits kept before saturation

  localparam logic [2:0] RGN_A    = 3'd0;
  localparam logic [2:0] RGN_B    = 3'd1;
  localparam logic [2:0] RGN_AB   = 3'd2;
  localparam logic [2:0] RGN_C    = 3'd3;
  localparam logic [2:0] RGN_AC   = 3'd4;
  localparam logic [2:0] RGN_BC   = 3'd5;
  localparam logic [2:0] RGN_FACE = 3'd6;

  typedef logic [2:0][CW-1:0]   cvec_t;
  typedef logic [2:0][DIFW-1:0] dvec_t;

  // Work handed from the classifier to the projection unit.
  typedef struct packed {
    cvec_t                   base;
    dvec_t                   e1;
    dvec_t                   e2;
    logic signed [VW-1:0]    w1;
    logic signed [VW-1:0]    w2;
    logic signed [DENW-1:0]  den;
    logic                    direct;
    logic [2:0]              region;
    logic                    degen;
  } job_t;

endpackage

>>> hdl/cpt_in_if.sv
// Query channel: one query point and three triangle vertices per transfer.
interface cpt_in_if import cpt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;
  logic signed [CW-1:0] vert_a_x;
  logic signed [CW-1:0] vert_a_y;
  logic signed [CW-1:0] vert_a_z;
  logic signed [CW-1:0] vert_b_x;
  logic signed [CW-1:0] vert_b_y;
  logic signed [CW-1:0] vert_b_z;
  logic signed [CW-1:0] vert_c_x;
  logic signed [CW-1:0] vert_c_y;
  logic signed [CW-1:0] vert_c_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output vert_a_x, output vert_a_y, output vert_a_z,
                  output vert_b_x, output vert_b_y, output vert_b_z,
                  output vert_c_x, output vert_c_y, output vert_c_z,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                input vert_a_x, input vert_a_y, input vert_a_z,
                input vert_b_x, input vert_b_y, input vert_b_z,
                input vert_c_x, input vert_c_y, input vert_c_z,
                output ready);
endinterface

>>> hdl/cpt_out_if.sv
// Result channel: nearest point, region code and degenerate flag per transfer.
interface cpt_out_if import cpt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] near_x;
  logic signed [CW-1:0] near_y;
  logic signed [CW-1:0] near_z;
  logic [2:0]           region;
  logic                 degenerate;

  modport source (output valid, output near_x, output near_y, output near_z,
                  output region, output degenerate, input ready);
  modport sink (input valid, input near_x, input near_y, input near_z,
                input region, input degenerate, output ready);
endinterface

>>> hdl/cpt_front.sv
// Front pipeline: dot products, 2x2 determinants and Voronoi region classification.
module cpt_front import cpt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cpt_in_if.sink    query,
  output logic      job_valid,
  output job_t      job,
  input  logic      job_ready
);

  localparam int PW = 2 * DIFW;
  localparam int PA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PB [6] = '{3, 1, 1, 5, 5, 3};

  typedef struct packed {
    cvec_t a;
    cvec_t b;
    cvec_t c;
    dvec_t ab;
    dvec_t ac;
    dvec_t bc;
  } geo_t;

  logic                    en;
  logic [7:1]              v;
  cvec_t                   pin, ain, bin, cin;
  geo_t                    geo [1:6];
  dvec_t                   ap1, bp1, cp1;
  logic signed [PW-1:0]    m [6][3];
  logic signed [DW-1:0]    d3r [6];
  logic signed [DW-1:0]    d4r [6];
  logic signed [DW-1:0]    d5r [6];
  logic signed [DW-1:0]    d6r [6];
  logic signed [2*SW-1:0]  pp [6][4];
  logic signed [VW-1:0]    prod [6];
  logic signed [VW-1:0]    va, vb, vc;
  logic signed [DW:0]      n5, s5;
  logic signed [DENW-1:0]  den_ab, den_ac, den_bc, den_in;
  job_t                    job_next;

  function automatic logic signed [DIFW-1:0] dif(input logic [CW-1:0] x,
                                                  input logic [CW-1:0] y);
    dif = DIFW'($signed(x)) - DIFW'($signed(y));
  endfunction

  function automatic logic signed [SW-1:0] hi(input logic [DW-1:0] d);
    hi = SW'($signed(d[DW-1:DW/2]));
  endfunction

  function automatic logic signed [SW-1:0] lo(input logic [DW-1:0] d);
    lo = $signed({1'b0, d[DW/2-1:0]});
  endfunction

  function automatic logic le0(input logic signed [VW-1:0] x);
    le0 = x[VW-1] || (x == '0);
  endfunction

  // The whole front advances together and holds while the queue is full.
  assign en          = !(v[7] && !job_ready);
  assign query.ready = en;
  assign job_valid   = v[7];

  assign pin = {query.point_z, query.point_y, query.point_x};
  assign ain = {query.vert_a_z, query.vert_a_y, query.vert_a_x};
  assign bin = {query.vert_b_z, query.vert_b_y, query.vert_b_x};
  assign cin = {query.vert_c_z, query.vert_c_y, query.vert_c_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:1], query.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo[1].a <= ain;
      geo[1].b <= bin;
      geo[1].c <= cin;
      for (int k = 0; k < 3; k++) begin
        geo[1].ab[k] <= dif(bin[k], ain[k]);
        geo[1].ac[k] <= dif(cin[k], ain[k]);
        geo[1].bc[k] <= dif(cin[k], bin[k]);
        ap1[k]       <= dif(pin[k], ain[k]);
        bp1[k]       <= dif(pin[k], bin[k]);
        cp1[k]       <= dif(pin[k], cin[k]);
      end
      for (int s = 2; s <= 6; s++) begin
        geo[s] <= geo[s-1];
      end

      for (int k = 0; k < 3; k++) begin
        m[0][k] <= $signed(geo[1].ab[k]) * $signed(ap1[k]);
        m[1][k] <= $signed(geo[1].ac[k]) * $signed(ap1[k]);
        m[2][k] <= $signed(geo[1].ab[k]) * $signed(bp1[k]);
        m[3][k] <= $signed(geo[1].ac[k]) * $signed(bp1[k]);
        m[4][k] <= $signed(geo[1].ab[k]) * $signed(cp1[k]);
        m[5][k] <= $signed(geo[1].ac[k]) * $signed(cp1[k]);
      end

      for (int i = 0; i < 6; i++) begin
        d3r[i] <= DW'(m[i][0]) + DW'(m[i][1]) + DW'(m[i][2]);
        d4r[i] <= d3r[i];
        d5r[i] <= d4r[i];
        d6r[i] <= d5r[i];
      end

      // Each product of two 52-bit dot products is formed from four partial products of 27-bit signed halves.
      for (int j = 0; j < 6; j++) begin
        pp[j][0] <= hi(d3r[PA[j]]) * hi(d3r[PB[j]]);
        pp[j][1] <= hi(d3r[PA[j]]) * lo(d3r[PB[j]]);
        pp[j][2] <= lo(d3r[PA[j]]) * hi(d3r[PB[j]]);
        pp[j][3] <= lo(d3r[PA[j]]) * lo(d3r[PB[j]]);
      end

      for (int j = 0; j < 6; j++) begin
        prod[j] <= (VW'(pp[j][0]) <<< DW)
                 + ((VW'(pp[j][1]) + VW'(pp[j][2])) <<< (DW/2))
                 + VW'(pp[j][3]);
      end

      vc <= prod[0] - prod[1];
      vb <= prod[2] - prod[3];
      va <= prod[4] - prod[5];

      job <= job_next;
    end
  end

  assign n5     = (DW+1)'(d6r[3]) - (DW+1)'(d6r[2]);
  assign s5     = (DW+1)'(d6r[4]) - (DW+1)'(d6r[5]);
  assign den_ab = DENW'(d6r[0]) - DENW'(d6r[2]);
  assign den_ac = DENW'(d6r[1]) - DENW'(d6r[5]);
  assign den_bc = DENW'(n5) + DENW'(s5);
  assign den_in = DENW'(va) + DENW'(vb) + DENW'(vc);

  // Tests run in the fixed order of the Voronoi region search.
  always_comb begin
    job_next.base   = geo[6].a;
    job_next.e1     = geo[6].ab;
    job_next.e2     = '0;
    job_next.w1     = '0;
    job_next.w2     = '0;
    job_next.den    = '0;
    job_next.direct = 1'b1;
    job_next.region = RGN_A;
    job_next.degen  = 1'b0;
    if (d6r[0] <= 0 && d6r[1] <= 0) begin
      job_next.region = RGN_A;
    end else if (d6r[2] >= 0 && d6r[3] <= d6r[2]) begin
      job_next.region = RGN_B;
      job_next.base   = geo[6].b;
    end else if (le0(vc) && d6r[0] >= 0 && d6r[2] <= 0) begin
      job_next.region = RGN_AB;
      job_next.w1     = VW'(d6r[0]);
      job_next.den    = den_ab;
      job_next.direct = (den_ab == '0);
      job_next.degen  = (den_ab == '0);
    end else if (d6r[5] >= 0 && d6r[4] <= d6r[5]) begin
      job_next.region = RGN_C;
      job_next.base   = geo[6].c;
    end else if (le0(vb) && d6r[1] >= 0 && d6r[5] <= 0) begin
      job_next.region = RGN_AC;
      job_next.e1     = geo[6].ac;
      job_next.w1     = VW'(d6r[1]);
      job_next.den    = den_ac;
      job_next.direct = (den_ac == '0);
      job_next.degen  = (den_ac == '0);
    end else if (le0(va) && n5 >= 0 && s5 >= 0) begin
      job_next.region = RGN_BC;
      job_next.base   = (den_bc == '0) ? geo[6].a : geo[6].b;
      job_next.e1     = geo[6].bc;
      job_next.w1     = VW'(n5);
      job_next.den    = den_bc;
      job_next.direct = (den_bc == '0);
      job_next.degen  = (den_bc == '0);
    end else begin
      job_next.region = RGN_FACE;
      job_next.e1     = geo[6].ab;
      job_next.w1     = vb;
      job_next.e2     = geo[6].ac;
      job_next.w2     = vc;
      job_next.den    = den_in;
      job_next.direct = (den_in == '0);
      job_next.degen  = (den_in == '0);
    end
  end

endmodule

>>> hdl/cpt_queue.sv
// Two-entry queue that decouples the classifier from the projection unit.
module cpt_queue import cpt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic wready,
  output logic rvalid,
  output job_t rdata,
  input  logic pop
);

  job_t       slot [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wready = (cnt != 2'd2);
  assign rvalid = (cnt != 2'd0);
  assign rdata  = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= wdata;
  end

endmodule

>>> hdl/cpt_back.sv
// Back pipeline: projection numerators, restoring division, rounding and saturation.
module cpt_back import cpt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      hd_valid,
  input  job_t      hd,
  output logic      hd_pop,
  cpt_out_if.source result
);

  localparam int NB = QB + 4;
  localparam int MW = SW + 1 + DIFW;

  typedef struct packed {
    cvec_t      base;
    logic       direct;
    logic [2:0] region;
    logic       degen;
  } tail_t;

  logic                   enb;
  logic [NB:1]            bvld;
  tail_t                  tl [1:NB-1];
  logic signed [MW-1:0]   bpart [3][2][NCH];
  logic signed [DENW-1:0] den1, den2;
  logic signed [NW-1:0]   acc [3];
  logic signed [NW-1:0]   num2 [3];
  logic [NW-1:0]          nabs [3];
  logic [DENW-1:0]        dabs;
  logic [NW-1:0]          dr [QB+1][3];
  logic [QB-1:0]          dq [QB+1][3];
  logic [DENW-1:0]        dd [QB+1];
  logic                   dn [QB+1][3];
  logic                   dov [QB+1][3];
  logic                   rnd [3];
  logic [QB:0]            qm [3];
  logic signed [QB+1:0]   off [3];
  logic signed [QB+2:0]   sum [3];
  logic [CW-1:0]          nearv [3];

  localparam logic signed [QB+2:0] CMAX = (QB+3)'(2**(CW-1) - 1);
  localparam logic signed [QB+2:0] CMIN = -(QB+3)'(2**(CW-1));
  localparam logic [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};

  function automatic logic signed [SW:0] chunk(input logic [VW-1:0] w, input int j);
    if (j == NCH - 1) chunk = (SW+1)'($signed(w[VW-1 -: SW]));
    else              chunk = $signed({1'b0, w[SW*j +: SW]});
  endfunction

  assign enb          = !(bvld[NB] && !result.ready);
  assign hd_pop       = enb && hd_valid;
  assign result.valid = bvld[NB];

  always_ff @(posedge clk) begin
    if (rst) begin
      bvld <= '0;
    end else if (enb) begin
      bvld <= {bvld[NB-1:1], hd_valid};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = '0;
      for (int s = 0; s < 2; s++) begin
        for (int j = 0; j < NCH; j++) begin
          acc[k] = acc[k] + (NW'(bpart[k][s][j]) <<< (SW*j));
        end
      end
      nabs[k] = num2[k][NW-1] ? NW'(-num2[k]) : NW'(num2[k]);
    end
    dabs = den2[DENW-1] ? DENW'(-den2) : DENW'(den2);
  end

  always_ff @(posedge clk) begin
    if (enb) begin
      tl[1].base   <= hd.base;
      tl[1].direct <= hd.direct;
      tl[1].region <= hd.region;
      tl[1].degen  <= hd.degen;
      for (int s = 2; s <= NB-1; s++) begin
        tl[s] <= tl[s-1];
      end
      den1 <= hd.den;
      den2 <= den1;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < NCH; j++) begin
          bpart[k][0][j] <= chunk(hd.w1, j) * $signed(hd.e1[k]);
          bpart[k][1][j] <= chunk(hd.w2, j) * $signed(hd.e2[k]);
        end
        num2[k] <= acc[k];
      end

      // A quotient of 2^QB or more always saturates, so it is flagged up front.
      dd[0] <= dabs;
      for (int k = 0; k < 3; k++) begin
        dr[0][k]  <= nabs[k];
        dq[0][k]  <= '0;
        dn[0][k]  <= num2[k][NW-1] ^ den2[DENW-1];
        dov[0][k] <= (nabs[k] >= (NW'(dabs) << QB));
      end

      for (int i = 0; i < QB; i++) begin
        dd[i+1] <= dd[i];
        for (int k = 0; k < 3; k++) begin
          dn[i+1][k]  <= dn[i][k];
          dov[i+1][k] <= dov[i][k];
          if (dr[i][k] >= (NW'(dd[i]) << (QB-1-i))) begin
            dr[i+1][k] <= dr[i][k] - (NW'(dd[i]) << (QB-1-i));
            dq[i+1][k] <= dq[i][k] | (QB'(1) << (QB-1-i));
          end else begin
            dr[i+1][k] <= dr[i][k];
            dq[i+1][k] <= dq[i][k];
          end
        end
      end

      result.near_x     <= nearv[0];
      result.near_y     <= nearv[1];
      result.near_z     <= nearv[2];
      result.region     <= tl[NB-1].region;
      result.degenerate <= tl[NB-1].degen;
    end
  end

  // Round half away from zero on the magnitude, then apply the sign and clamp; direct jobs return the base point.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = ({dr[QB][k], 1'b0} >= (NW+1)'(dd[QB]));
      qm[k]  = (QB+1)'(dq[QB][k]) + (QB+1)'(rnd[k]);
      off[k] = dn[QB][k] ? -$signed({1'b0, qm[k]}) : $signed({1'b0, qm[k]});
      sum[k] = (QB+3)'($signed(tl[NB-1].base[k])) + (QB+3)'(off[k]);
      if (tl[NB-1].direct) begin
        nearv[k] = tl[NB-1].base[k];
      end else if (dov[QB][k]) begin
        nearv[k] = dn[QB][k] ? VMIN : VMAX;
      end else if (sum[k] > CMAX) begin
        nearv[k] = VMAX;
      end else if (sum[k] < CMIN) begin
        nearv[k] = VMIN;
      end else begin
        nearv[k] = sum[k][CW-1:0];
      end
    end
  end

endmodule

>>> hdl/closest_point_on_triangle_top.sv
// Top level of the closest-point-on-triangle block.
// The query channel takes a point and three triangle vertices in signed
// fixed point; the result channel returns the nearest point on the triangle,
// its Voronoi region code and a flag for a zero divisor on a degenerate
// triangle, in which case vertex a is returned.
// Both channels use valid/ready; a transfer happens when both are high.
// One query is taken per cycle when the result side keeps up, and results
// leave in query order. A query passes through dot products, determinants
// and classification, then through the queue, and then through numerator
// products, a 26-step restoring divider with one quotient bit per stage,
// and rounding.
// When the receiver stalls, the back pipeline holds, the two-entry queue
// fills, and then the front holds and drops ready.
// Reset clears all valid bits and the queue pointers and count; data registers are not reset.
module closest_point_on_triangle_top import cpt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cpt_in_if.sink    query,
  cpt_out_if.source result
);

  logic job_valid, job_ready, push;
  logic hd_valid, hd_pop;
  job_t job, hd;

  assign push = job_valid && job_ready;

  cpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .query     (query),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  cpt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (job),
    .wready (job_ready),
    .rvalid (hd_valid),
    .rdata  (hd),
    .pop    (hd_pop)
  );

  cpt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .hd_valid (hd_valid),
    .hd       (hd),
    .hd_pop   (hd_pop),
    .result   (result)
  );

endmodule

>>> test/cpt_test_if.sv
// Testbench-side interface instances are the RTL interfaces; this file holds the query and result record types.
package cpt_test_pkg;
  import cpt_pkg::*;

  typedef struct {
    logic signed [CW-1:0] p[3];
    logic signed [CW-1:0] a[3];
    logic signed [CW-1:0] b[3];
    logic signed [CW-1:0] c[3];
  } query_t;

  typedef struct {
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic signed [CW-1:0] nz;
    logic [2:0]           region;
    logic                 degenerate;
  } nearest_t;
endpackage

>>> test/closest_point_on_triangle_top_test.sv
// Testbench for the closest-point-on-triangle block: random and directed queries checked in order.
module closest_point_on_triangle_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cpt_pkg::*;
  import cpt_test_pkg::*;

  localparam int LATENCY = 38;

  logic clk = 0;
  logic rst = 1;
  cpt_in_if  query();
  cpt_out_if result();

  closest_point_on_triangle_top dut (.clk(clk), .rst(rst), .query(query), .result(result));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  query_t   pending_q[$];
  nearest_t nearest_q[$];
  int       mismatches = 0;
  bit       calm = 0;
  bit       hold = 0;
  int       hold_cnt = 0;
  int       src_gap = 0;
  int       snk_gap = 0;

  // Rounds n/d to nearest with ties away from zero; magnitude capped at 2^40.
  function automatic longint round_quot(logic signed [255:0] n, logic signed [255:0] d);
    logic [255:0] un, ud, q, r;
    longint s;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = un / ud;
    r = un % ud;
    if (2 * r >= ud) q = q + 1;
    if (q > (256'd1 << 40)) q = 256'd1 << 40;
    s = longint'(q[63:0]);
    return ((n < 0) != (d < 0)) ? -s : s;
  endfunction

  function automatic logic signed [CW-1:0] clamp24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[CW-1:0];
  endfunction

  function automatic longint dot(longint u[3], longint v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic nearest_t closest_point(query_t t);
    nearest_t o;
    longint p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
    longint d1, d2, d3, d4, d5, d6, den, num;
    logic signed [255:0] va, vb, vc, wden;
    longint base[3], nr[3];
    for (int k = 0; k < 3; k++) begin
      p[k] = t.p[k]; a[k] = t.a[k]; b[k] = t.b[k]; c[k] = t.c[k];
      ab[k] = b[k] - a[k]; ac[k] = c[k] - a[k]; bc[k] = c[k] - b[k];
      ap[k] = p[k] - a[k]; bp[k] = p[k] - b[k]; cp[k] = p[k] - c[k];
      nr[k] = a[k];
    end
    d1 = dot(ab, ap); d2 = dot(ac, ap); d3 = dot(ab, bp);
    d4 = dot(ac, bp); d5 = dot(ab, cp); d6 = dot(ac, cp);
    vc = 256'(signed'(d1)) * d4 - 256'(signed'(d3)) * d2;
    vb = 256'(signed'(d5)) * d2 - 256'(signed'(d1)) * d6;
    va = 256'(signed'(d3)) * d6 - 256'(signed'(d5)) * d4;
    o.degenerate = 0;
    if (d1 <= 0 && d2 <= 0) begin
      o.region = RGN_A;
    end else if (d3 >= 0 && d4 <= d3) begin
      o.region = RGN_B; nr = b;
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      o.region = RGN_AB; den = d1 - d3;
      if (den == 0) o.degenerate = 1;
      else for (int k = 0; k < 3; k++)
        nr[k] = clamp24(a[k] + round_quot(256'(signed'(ab[k])) * d1, den));
    end else if (d6 >= 0 && d5 <= d6) begin
      o.region = RGN_C; nr = c;
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      o.region = RGN_AC; den = d2 - d6;
      if (den == 0) o.degenerate = 1;
      else for (int k = 0; k < 3; k++)
        nr[k] = clamp24(a[k] + round_quot(256'(signed'(ac[k])) * d2, den));
    end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
      o.region = RGN_BC; num = d4 - d3; den = num + (d5 - d6);
      if (den == 0) o.degenerate = 1;
      else for (int k = 0; k < 3; k++)
        nr[k] = clamp24(b[k] + round_quot(256'(signed'(bc[k])) * num, den));
    end else begin
      o.region = RGN_FACE; wden = va + vb + vc;
      if (wden == 0) o.degenerate = 1;
      else for (int k = 0; k < 3; k++)
        nr[k] = clamp24(a[k] + round_quot(vb * ab[k] + vc * ac[k], wden));
    end
    o.nx = CW'(nr[0]); o.ny = CW'(nr[1]); o.nz = CW'(nr[2]);
    return o;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(int span);
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return CW'($urandom);
      default: return CW'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic query_t make_query(int span);
    query_t t;
    for (int k = 0; k < 3; k++) begin
      t.p[k] = rand_coord(span * 2); t.a[k] = rand_coord(span);
      t.b[k] = rand_coord(span); t.c[k] = rand_coord(span);
    end
    case ($urandom_range(0, 11))
      0: t.b = t.a;
      1: begin t.b = t.a; t.c = t.a; end
      2: for (int k = 0; k < 3; k++) t.c[k] = CW'(2 * t.b[k] - t.a[k]);
      3: t.p = t.a;
      default: ;
    endcase
    return t;
  endfunction

  function automatic query_t fill_query(logic signed [CW-1:0] v);
    query_t t;
    for (int k = 0; k < 3; k++) begin t.p[k] = v; t.a[k] = v; t.b[k] = v; t.c[k] = v; end
    return t;
  endfunction

  function automatic query_t unit_triangle(longint px, longint py, longint pz);
    query_t t;
    t.a = '{0, 0, 0}; t.b = '{4096, 0, 0}; t.c = '{0, 4096, 0};
    t.p = '{CW'(px), CW'(py), CW'(pz)};
    return t;
  endfunction

  // Driver: each transfer takes the next query from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      query.valid <= 0;
    end else begin
      if (query.valid && query.ready) nearest_q.push_back(closest_point(pending_q.pop_front()));
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        query.valid <= 0;
      end else if (!(query.valid && !query.ready) && !calm && $urandom_range(0, 15) == 0) begin
        src_gap <= $urandom_range(1, 11) - 1;
        query.valid <= 0;
      end else begin
        // Look past the head only if the head went out at this edge.
        if (query.valid && query.ready ? pending_q.size() > 0 : pending_q.size() > 0) begin
          query.valid <= 1;
          {query.point_x, query.point_y, query.point_z} <=
            {pending_q[0].p[0], pending_q[0].p[1], pending_q[0].p[2]};
          {query.vert_a_x, query.vert_a_y, query.vert_a_z} <=
            {pending_q[0].a[0], pending_q[0].a[1], pending_q[0].a[2]};
          {query.vert_b_x, query.vert_b_y, query.vert_b_z} <=
            {pending_q[0].b[0], pending_q[0].b[1], pending_q[0].b[2]};
          {query.vert_c_x, query.vert_c_y, query.vert_c_z} <=
            {pending_q[0].c[0], pending_q[0].c[1], pending_q[0].c[2]};
        end else begin
          query.valid <= 0;
        end
      end
    end
  end

  // The receiver holds off once for a long stretch while queries keep coming.
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
      hold <= 0;
    end else begin
      hold_cnt <= hold_cnt + 1;
      hold <= (hold_cnt >= 1000 && hold_cnt < 1200);
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    nearest_t e;
    if (rst) begin
      result.ready <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (nearest_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer");
        end else begin
          e = nearest_q.pop_front();
          if (result.near_x !== e.nx || result.near_y !== e.ny || result.near_z !== e.nz ||
              result.region !== e.region || result.degenerate !== e.degenerate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d %0d %0d r%0d d%0d, got %0d %0d %0d r%0d d%0d",
                       e.nx, e.ny, e.nz, e.region, e.degenerate, result.near_x,
                       result.near_y, result.near_z, result.region, result.degenerate);
          end
        end
      end
      if (hold) begin
        result.ready <= 0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        result.ready <= 0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        snk_gap <= $urandom_range(1, 11) - 1;
        result.ready <= 0;
      end else begin
        result.ready <= 1;
      end
    end
  end

  initial begin
    query.valid = 0;
    {query.point_x, query.point_y, query.point_z} = '0;
    {query.vert_a_x, query.vert_a_y, query.vert_a_z} = '0;
    {query.vert_b_x, query.vert_b_y, query.vert_b_z} = '0;
    {query.vert_c_x, query.vert_c_y, query.vert_c_z} = '0;
    result.ready = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    // Directed: each region, fully degenerate triangles, and the field extremes.
    pending_q.push_back(unit_triangle(-4096, -4096, 0));
    pending_q.push_back(unit_triangle(8192, -100, 0));
    pending_q.push_back(unit_triangle(2048, -4096, 777));
    pending_q.push_back(unit_triangle(-100, 8192, 0));
    pending_q.push_back(unit_triangle(-4096, 2048, -5));
    pending_q.push_back(unit_triangle(4096, 4096, 1));
    pending_q.push_back(unit_triangle(1000, 1000, 4096));
    pending_q.push_back(unit_triangle(1365, 1365, 0));
    pending_q.push_back(fill_query(0));
    pending_q.push_back(fill_query(24'sh7FFFFF));
    pending_q.push_back(fill_query(24'sh800000));
    begin
      query_t t;
      t = fill_query(24'sh800000);
      t.p = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
      t.c = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF};
      pending_q.push_back(t);
      t.b = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000};
      pending_q.push_back(t);
      t = unit_triangle(5000, 5000, 0);
      t.c = '{8192, 0, 0};
      pending_q.push_back(t);
      t.p = '{-3, 9, 2};
      pending_q.push_back(t);
    end
    for (int i = 0; i < 1500; i++) begin
      if (i == 1300) calm = 1;
      pending_q.push_back(make_query(i % 7 == 0 ? 8388607 : 1 << $urandom_range(4, 20)));
      while (pending_q.size() > 40) @(posedge clk);
    end
    while (pending_q.size() > 0 || query.valid) @(posedge clk);
    while (nearest_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && nearest_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
